@@ hw/rtl/tob_pkg.sv @@
// ----------------------------------------------------------------------------
// tob_pkg
// Shared types and constants of the TCP option builder: request modes,
// option kinds and the decoded request record passed to the byte emitter.
// ----------------------------------------------------------------------------
package tob_pkg;

  // Size of the option area in bytes
  localparam int unsigned MaxOptionBytes = 40;
  // Longest single option (timestamps)
  localparam int unsigned MaxRunBytes    = 10;

  localparam int unsigned LenW = 6;
  localparam int unsigned CntW = 4;

  typedef enum logic [2:0] {
    MODE_CLEAR   = 3'd0,
    MODE_NOP     = 3'd1,
    MODE_MSS     = 3'd2,
    MODE_WSCALE  = 3'd3,
    MODE_SACKOK  = 3'd4,
    MODE_TSTAMP  = 3'd5,
    MODE_PAD     = 3'd6,
    MODE_INVALID = 3'd7
  } mode_e;

  // Option kinds and lengths
  localparam logic [7:0] KindNop    = 8'h01;
  localparam logic [7:0] KindMss    = 8'h02;
  localparam logic [7:0] LenMss     = 8'h04;
  localparam logic [7:0] KindWscale = 8'h03;
  localparam logic [7:0] LenWscale  = 8'h03;
  localparam logic [7:0] KindSackOk = 8'h04;
  localparam logic [7:0] LenSackOk  = 8'h02;
  localparam logic [7:0] KindTstamp = 8'h08;
  localparam logic [7:0] LenTstamp  = 8'h0A;

  // One decoded request; count of zero means a single item without a byte
  typedef struct packed {
    logic [MaxRunBytes-1:0][7:0] bytes;
    logic [CntW-1:0]             count;
    logic [LenW-1:0]             base;
    logic                        status;
    logic [LenW-1:0]             len_after;
    logic [5:0]                  mask_after;
  } req_t;

endpackage

@@ hw/rtl/tob_encode.sv @@
// ----------------------------------------------------------------------------
// tob_encode
// Encodes one option request against the current area length and mask:
// builds the option bytes, checks for overflow and gives the next state.
// ----------------------------------------------------------------------------
module tob_encode
  import tob_pkg::*;
(
  input  logic [2:0]      mode_i,
  input  logic [31:0]     first_value_i,
  input  logic [31:0]     second_value_i,
  input  logic [LenW-1:0] len_i,
  input  logic [5:0]      mask_i,
  output req_t            req_o,
  output logic [LenW-1:0] len_next_o,
  output logic [5:0]      mask_next_o
);

  logic [MaxRunBytes-1:0][7:0] bytes;
  logic [CntW-1:0]             n;
  logic                        known;
  logic                        overflow;
  logic [6:0]                  room;
  logic [LenW-1:0]             len_sum;
  logic [5:0]                  mask_add;

  // Build the option bytes for the mode
  always_comb begin
    bytes = '0;
    n     = '0;
    known = 1'b1;
    case (mode_e'(mode_i))
      MODE_NOP: begin
        bytes[0] = KindNop;
        n        = CntW'(1);
      end
      MODE_MSS: begin
        bytes[0] = KindMss;
        bytes[1] = LenMss;
        bytes[2] = first_value_i[15:8];
        bytes[3] = first_value_i[7:0];
        n        = CntW'(4);
      end
      MODE_WSCALE: begin
        bytes[0] = KindWscale;
        bytes[1] = LenWscale;
        bytes[2] = first_value_i[7:0];
        n        = CntW'(3);
      end
      MODE_SACKOK: begin
        bytes[0] = KindSackOk;
        bytes[1] = LenSackOk;
        n        = CntW'(2);
      end
      MODE_TSTAMP: begin
        bytes[0] = KindTstamp;
        bytes[1] = LenTstamp;
        bytes[2] = first_value_i[31:24];
        bytes[3] = first_value_i[23:16];
        bytes[4] = first_value_i[15:8];
        bytes[5] = first_value_i[7:0];
        bytes[6] = second_value_i[31:24];
        bytes[7] = second_value_i[23:16];
        bytes[8] = second_value_i[15:8];
        bytes[9] = second_value_i[7:0];
        n        = CntW'(10);
      end
      MODE_PAD: begin
        // zero bytes up to the next multiple of four
        n = CntW'((2'd0 - len_i[1:0]) & 2'd3);
      end
      MODE_CLEAR: begin
        n = '0;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // Reject on overflow of the area or an unknown mode
  assign room     = 7'(MaxOptionBytes) - 7'(len_i);
  assign overflow = (7'(len_i) > 7'(MaxOptionBytes)) || (7'(n) > room);
  assign len_sum  = len_i + LenW'(n);
  assign mask_add = 6'(1) << (mode_i - 3'd1);

  // Next state and the request record
  always_comb begin
    req_o.bytes = bytes;
    req_o.base  = len_i;
    if (mode_e'(mode_i) == MODE_CLEAR) begin
      len_next_o       = '0;
      mask_next_o      = '0;
      req_o.count      = '0;
      req_o.status     = 1'b0;
      req_o.len_after  = '0;
      req_o.mask_after = '0;
    end else if (!known || overflow) begin
      len_next_o       = len_i;
      mask_next_o      = mask_i;
      req_o.count      = '0;
      req_o.status     = 1'b1;
      req_o.len_after  = len_i;
      req_o.mask_after = mask_i;
    end else begin
      len_next_o       = len_sum;
      mask_next_o      = mask_i | mask_add;
      req_o.count      = n;
      req_o.status     = 1'b0;
      req_o.len_after  = len_sum;
      req_o.mask_after = mask_i | mask_add;
    end
  end

endmodule

@@ hw/rtl/tcp_option_builder_core.sv @@
// ----------------------------------------------------------------------------
// tcp_option_builder_core
// Appends TCP header options to a 40-byte option area, one request per
// input transaction, and emits each written byte with its offset.
// ----------------------------------------------------------------------------
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------------
//   in      | in_valid_i/ready_o  | mode_i, first_value_i, second_value_i
//   out     | out_valid_o/ready_i | out_byte_o, byte_valid_o, byte_offset_o,
//           |                     | last_of_run_o, status_o, length_after_o,
//           |                     | options_present_o
//
// A request gives one output transaction per written byte (1 to 10) or one
// when nothing is written. The next request is taken in the cycle the last
// item of the current one leaves, so the output runs without gaps while
// requests are offered. Reset empties the area and the option mask. A
// stalled output holds the current item and the input.
// ----------------------------------------------------------------------------
module tcp_option_builder_core
  import tob_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [2:0]      mode_i,
  input  logic [31:0]     first_value_i,
  input  logic [31:0]     second_value_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            byte_valid_o,
  output logic [LenW-1:0] byte_offset_o,
  output logic            last_of_run_o,
  output logic            status_o,
  output logic [LenW-1:0] length_after_o,
  output logic [5:0]      options_present_o
);

  logic [LenW-1:0] len_q, len_d;
  logic [5:0]      mask_q, mask_d;
  logic            busy_q;
  logic [CntW-1:0] idx_q;
  req_t            req_q, req_d;
  logic            in_fire, out_fire, last;

  tob_encode u_encode (
    .mode_i        (mode_i),
    .first_value_i (first_value_i),
    .second_value_i(second_value_i),
    .len_i         (len_q),
    .mask_i        (mask_q),
    .req_o         (req_d),
    .len_next_o    (len_d),
    .mask_next_o   (mask_d)
  );

  // Drive the current item from the held request
  assign last     = (req_q.count == '0) || (idx_q == req_q.count - CntW'(1));
  assign out_fire = busy_q && out_ready_i;
  assign in_ready_o = !busy_q || (out_ready_i && last);
  assign in_fire  = in_valid_i && in_ready_o;

  assign out_valid_o       = busy_q;
  assign byte_valid_o      = (req_q.count != '0);
  assign out_byte_o        = (req_q.count != '0) ? req_q.bytes[idx_q] : 8'h00;
  assign byte_offset_o     = (req_q.count != '0) ? req_q.base + LenW'(idx_q) : '0;
  assign last_of_run_o     = last;
  assign status_o          = req_q.status;
  assign length_after_o    = req_q.len_after;
  assign options_present_o = req_q.mask_after;

  // Update area state at acceptance; advance through the run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      mask_q <= '0;
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      if (in_fire) begin
        len_q  <= len_d;
        mask_q <= mask_d;
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (out_fire) begin
        if (last) begin
          busy_q <= 1'b0;
        end else begin
          idx_q <= idx_q + CntW'(1);
        end
      end
    end
  end

  // Hold the decoded request
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= req_d;
    end
  end

endmodule

@@ sim/tb_tcp_option_builder_core.sv @@
// ----------------------------------------------------------------------------
// tb_tcp_option_builder_core
// Self-checking bench for the TCP option builder. A directed sequence walks
// every mode, the field extremes, overflow and the aligned pad. Random option
// sequences follow, each mostly opened by a clear. The bench models the area
// length and the option mask, predicts every emitted byte and checks the
// output transactions in order. The sender runs in bursts and the receiver
// stalls, including long hold-offs that back up the input.
// ----------------------------------------------------------------------------
module tb_tcp_option_builder_core;
  import tob_pkg::*;

  localparam logic StatusOk     = 1'b0;
  localparam logic StatusReject = 1'b1;
  localparam int   NumRequests  = 220;
  localparam int   HoldCycles   = 300;

  typedef struct {
    mode_e       mode;
    logic [31:0] first;
    logic [31:0] second;
  } opt_req_t;

  typedef struct packed {
    logic [7:0]      data;
    logic            written;
    logic [LenW-1:0] offset;
    logic            last;
    logic            status;
    logic [LenW-1:0] len_after;
    logic [5:0]      present;
  } opt_byte_t;

  logic            clk_i          = 1'b0;
  logic            rst_ni         = 1'b0;
  logic            in_valid_i     = 1'b0;
  logic            in_ready_o;
  logic [2:0]      mode_i         = '0;
  logic [31:0]     first_value_i  = '0;
  logic [31:0]     second_value_i = '0;
  logic            out_valid_o;
  logic            out_ready_i    = 1'b0;
  logic [7:0]      out_byte_o;
  logic            byte_valid_o;
  logic [LenW-1:0] byte_offset_o;
  logic            last_of_run_o;
  logic            status_o;
  logic [LenW-1:0] length_after_o;
  logic [5:0]      options_present_o;

  opt_req_t  request_q[$];
  opt_byte_t pending_bytes[$];

  // Shadow of the option area
  int         area_len;
  logic [5:0] opt_mask;

  int n_queued;
  int n_accepted;
  int n_results;
  int n_written;
  int n_rejected;
  int n_errors;
  int mode_hits [8];

  // Sender burst control
  int burst_left;
  int gap_left;

  // Receiver stall control
  int         hold_left;
  int         holds_done;
  logic [6:0] stall_phase;

  opt_byte_t got;
  opt_byte_t want;
  opt_req_t  drv_req;

  tcp_option_builder_core i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .mode_i            (mode_i),
    .first_value_i     (first_value_i),
    .second_value_i    (second_value_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_byte_o        (out_byte_o),
    .byte_valid_o      (byte_valid_o),
    .byte_offset_o     (byte_offset_o),
    .last_of_run_o     (last_of_run_o),
    .status_o          (status_o),
    .length_after_o    (length_after_o),
    .options_present_o (options_present_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Queue one expected output transaction
  function automatic void add_expected(input logic [7:0] data, input logic written,
                                       input int offset, input logic last,
                                       input logic status, input int len,
                                       input logic [5:0] mask);
    opt_byte_t e;
    e.data      = data;
    e.written   = written;
    e.offset    = LenW'(offset);
    e.last      = last;
    e.status    = status;
    e.len_after = LenW'(len);
    e.present   = mask;
    pending_bytes.push_back(e);
  endfunction

  // Encode one request against the shadow area and queue its bytes
  function automatic void predict_option(input mode_e m, input logic [31:0] a,
                                         input logic [31:0] b);
    logic [7:0] seq [MaxRunBytes];
    int         n;
    int         base;
    logic       bad_mode;
    base     = area_len;
    n        = 0;
    bad_mode = 1'b0;
    for (int i = 0; i < MaxRunBytes; i++) seq[i] = 8'h00;
    case (m)
      MODE_CLEAR: begin
        area_len = 0;
        opt_mask = '0;
        add_expected(8'h00, 1'b0, 0, 1'b1, StatusOk, 0, 6'h00);
        return;
      end
      MODE_NOP: begin
        seq[0] = KindNop;
        n = 1;
      end
      MODE_MSS: begin
        seq[0] = KindMss;
        seq[1] = LenMss;
        seq[2] = a[15:8];
        seq[3] = a[7:0];
        n = 4;
      end
      MODE_WSCALE: begin
        seq[0] = KindWscale;
        seq[1] = LenWscale;
        seq[2] = a[7:0];
        n = 3;
      end
      MODE_SACKOK: begin
        seq[0] = KindSackOk;
        seq[1] = LenSackOk;
        n = 2;
      end
      MODE_TSTAMP: begin
        seq[0] = KindTstamp;
        seq[1] = LenTstamp;
        for (int i = 0; i < 4; i++) begin
          seq[2 + i] = a[31 - 8*i -: 8];
          seq[6 + i] = b[31 - 8*i -: 8];
        end
        n = 10;
      end
      MODE_PAD: n = (4 - (base & 3)) & 3;
      default: bad_mode = 1'b1;
    endcase

    // Reject unknown modes and anything that runs past the area
    if (bad_mode || base > MaxOptionBytes || n > MaxOptionBytes - base) begin
      add_expected(8'h00, 1'b0, 0, 1'b1, StatusReject, base, opt_mask);
      n_rejected++;
      return;
    end

    area_len = base + n;
    opt_mask = opt_mask | (6'h01 << (int'(m) - 1));
    if (n == 0) begin
      add_expected(8'h00, 1'b0, 0, 1'b1, StatusOk, area_len, opt_mask);
    end else begin
      for (int i = 0; i < n; i++)
        add_expected(seq[i], 1'b1, base + i, i == n - 1, StatusOk, area_len, opt_mask);
      n_written += n;
    end
  endfunction

  task automatic queue_request(input mode_e m, input logic [31:0] a, input logic [31:0] b);
    opt_req_t r;
    r.mode   = m;
    r.first  = a;
    r.second = b;
    request_q.push_back(r);
    n_queued++;
  endtask

  // Mix plain random words with the all-zero and all-one extremes
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Driver: offer requests in bursts separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      mode_i         <= '0;
      first_value_i  <= '0;
      second_value_i <= '0;
      burst_left     <= 0;
      gap_left       <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (gap_left != 0) begin
        gap_left   <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (request_q.size() != 0) begin
        drv_req = request_q.pop_front();
        in_valid_i     <= 1'b1;
        mode_i         <= drv_req.mode;
        first_value_i  <= drv_req.first;
        second_value_i <= drv_req.second;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: stall on a rotating pattern, with long hold-offs to back up the input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
      holds_done  <= 0;
      stall_phase <= '0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (holds_done < 2 && n_accepted >= 40 + 100 * holds_done) begin
      hold_left   <= HoldCycles;
      holds_done  <= holds_done + 1;
      out_ready_i <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1'b1;
      case (stall_phase[6:5])
        2'd0:    out_ready_i <= 1'b1;
        2'd1:    out_ready_i <= ($urandom_range(0, 3) != 0);
        2'd2:    out_ready_i <= stall_phase[1];
        default: out_ready_i <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  // Monitor: predict on each accepted request, then check each output transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_len   = 0;
      opt_mask   = '0;
      n_accepted <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_option(mode_e'(mode_i), first_value_i, second_value_i);
        mode_hits[mode_i]++;
        n_accepted <= n_accepted + 1;
      end
      if (out_valid_o && out_ready_i) begin
        got = '{out_byte_o, byte_valid_o, byte_offset_o, last_of_run_o, status_o,
                length_after_o, options_present_o};
        if (pending_bytes.size() == 0) begin
          $display("%0t: unexpected output, none expected; actual byte=%02h vld=%b off=%0d",
                   $time, got.data, got.written, got.offset);
          n_errors++;
        end else begin
          want = pending_bytes.pop_front();
          if (got !== want) begin
            $display("%0t: output %0d mismatch, expected byte=%02h vld=%b off=%0d last=%b",
                     $time, n_results, want.data, want.written, want.offset, want.last,
                     " st=%b len=%0d mask=%02h", want.status, want.len_after, want.present);
            $display("%0t:   actual byte=%02h vld=%b off=%0d last=%b st=%b len=%0d mask=%02h",
                     $time, got.data, got.written, got.offset, got.last, got.status,
                     got.len_after, got.present);
            n_errors++;
          end
        end
        n_results++;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    n_queued   = 0;
    n_results  = 0;
    n_written  = 0;
    n_rejected = 0;
    n_errors   = 0;
    foreach (mode_hits[i]) mode_hits[i] = 0;

    // Walk every mode from the empty area
    queue_request(MODE_PAD,     32'h0000_0000, 32'h0000_0000);
    queue_request(MODE_NOP,     32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(MODE_PAD,     32'h1234_5678, 32'h9ABC_DEF0);
    queue_request(MODE_MSS,     32'hFFFF_FFFF, 32'h0000_0000);
    queue_request(MODE_MSS,     32'h0000_0000, 32'hFFFF_FFFF);
    queue_request(MODE_WSCALE,  32'h0000_00FF, 32'h0000_0000);
    queue_request(MODE_WSCALE,  32'hFFFF_FF00, 32'h0000_0000);
    queue_request(MODE_SACKOK,  32'h0000_0000, 32'h0000_0000);
    queue_request(MODE_INVALID, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(MODE_CLEAR,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Fill the area exactly, then push past it
    queue_request(MODE_TSTAMP,  32'hFFFF_FFFF, 32'h0000_0000);
    queue_request(MODE_TSTAMP,  32'h0000_0000, 32'hFFFF_FFFF);
    queue_request(MODE_TSTAMP,  32'hA5A5_A5A5, 32'h5A5A_5A5A);
    queue_request(MODE_MSS,     32'h0000_05B4, 32'h0000_0000);
    queue_request(MODE_TSTAMP,  32'h0102_0304, 32'h0506_0708);
    queue_request(MODE_WSCALE,  32'h0000_000E, 32'h0000_0000);
    queue_request(MODE_SACKOK,  32'h0000_0000, 32'h0000_0000);
    queue_request(MODE_NOP,     32'h0000_0000, 32'h0000_0000);
    queue_request(MODE_NOP,     32'h0000_0000, 32'h0000_0000);
    queue_request(MODE_PAD,     32'h0000_0000, 32'h0000_0000);
    queue_request(MODE_INVALID, 32'h0000_0000, 32'h0000_0000);
    queue_request(MODE_CLEAR,   32'h0000_0000, 32'h0000_0000);

    // Mostly well-formed option lists, with some raw noise mixed in
    while (n_queued < NumRequests) begin
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 4) != 0)
          queue_request(MODE_CLEAR, rand_word(), rand_word());
        repeat ($urandom_range(2, 7))
          queue_request(mode_e'($urandom_range(1, 6)), rand_word(), rand_word());
      end else begin
        repeat ($urandom_range(1, 4))
          queue_request(mode_e'($urandom_range(0, 7)), rand_word(), rand_word());
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain the sender, then the expected outputs, then let the block settle
    while (request_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (4 * MaxRunBytes) @(posedge clk_i);

    $display("Run covered %0d requests (%0d rejected), %0d outputs with %0d option bytes.",
             n_accepted, n_rejected, n_results, n_written);
    $display("Requests per mode clear..invalid: %0d %0d %0d %0d %0d %0d %0d %0d",
             mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3],
             mode_hits[4], mode_hits[5], mode_hits[6], mode_hits[7]);
    if (n_errors == 0 && pending_bytes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/tob_pkg.sv
hw/rtl/tob_encode.sv
hw/rtl/tcp_option_builder_core.sv
sim/tb_tcp_option_builder_core.sv
